// File: rtl/hfrx_pkg.sv
// Shared types, codes and check-field functions for the HDLC frame receiver.
// No dependencies; imported by every module of the receiver.
`timescale 1ns / 1ps
`default_nettype none

package hfrx_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;

  // Result status codes.
  localparam logic [2:0] ST_START  = 3'd0;
  localparam logic [2:0] ST_DATA   = 3'd1;
  localparam logic [2:0] ST_ESCAPE = 3'd2;
  localparam logic [2:0] ST_GOOD   = 3'd3;
  localparam logic [2:0] ST_OOS    = 3'd4;
  localparam logic [2:0] ST_BAD    = 3'd5;
  localparam logic [2:0] ST_LARGE  = 3'd6;

  // Check field modes.
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SUM   = 2'd1;
  localparam logic [1:0] MODE_FCS16 = 2'd2;
  localparam logic [1:0] MODE_FCS32 = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_FCS_MODE = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam logic [15:0] FCS16_GOOD = 16'hF0B8;
  localparam logic [31:0] FCS32_GOOD = 32'hDEBB20E3;

  typedef enum logic [2:0] {
    KIND_START,
    KIND_DATA,
    KIND_ESC,
    KIND_CLOSE,
    KIND_OOS
  } item_kind_t;

  // One classified line byte as handed from the front end to the back end.
  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data;
  } item_t;

  function automatic logic [15:0] fcs16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] fcs32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hfrx_front.sv
// Front end of the HDLC frame receiver: tracks flag and escape framing and
// classifies each line byte. Depends on hfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfrx_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire logic [7:0]     rx_byte,
  output hfrx_pkg::item_t     item
);
  import hfrx_pkg::*;

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] prev_r, prev_nxt;

  always_comb begin
    in_frame_nxt = in_frame_r;
    prev_nxt     = prev_r;
    item.data    = rx_byte;
    if (!in_frame_r) begin
      if (rx_byte == FLAG_BYTE) begin
        item.kind    = KIND_START;
        in_frame_nxt = 1'b1;
        prev_nxt     = rx_byte;
      end else begin
        item.kind = KIND_OOS;
      end
    end else if (rx_byte == FLAG_BYTE && prev_r == FLAG_BYTE) begin
      // A doubled flag leaves the frame open.
      item.kind = KIND_OOS;
    end else if (rx_byte == FLAG_BYTE) begin
      item.kind    = KIND_CLOSE;
      in_frame_nxt = 1'b0;
    end else if (rx_byte == ESC_BYTE) begin
      item.kind = KIND_ESC;
      prev_nxt  = rx_byte;
    end else begin
      item.kind = KIND_DATA;
      item.data = (prev_r == ESC_BYTE) ? (rx_byte ^ ESC_XOR) : rx_byte;
      prev_nxt  = rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      prev_r     <= 8'h00;
    end else if (push) begin
      in_frame_r <= in_frame_nxt;
      prev_r     <= prev_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hfrx_fifo.sv
// Two-entry queue of classified words between the front and back ends.
// Depends on hfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfrx_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hfrx_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                pop_valid,
  output hfrx_pkg::item_t     pop_item
);
  import hfrx_pkg::*;

  item_t      mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/hfrx_back.sv
// Back end of the HDLC frame receiver: frame length count, check field
// accumulation, close checks and the output register. Depends on hfrx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hfrx_back #(
  parameter int MAX_BUFFER = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     fcs_mode,
  input  wire logic [12:0]    buffer_capacity,
  input  wire logic           item_valid,
  input  wire hfrx_pkg::item_t item,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          status,
  output logic                store_byte,
  output logic [7:0]          data_byte,
  output logic [15:0]         byte_index,
  output logic [15:0]         payload_length
);
  import hfrx_pkg::*;

  localparam logic [15:0] MaxBuf = 16'(MAX_BUFFER);

  logic [15:0] count_r, count_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        out_valid_r;
  logic [2:0]  status_r, status_nxt;
  logic        store_r, store_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [15:0] index_r, index_nxt;
  logic [15:0] plen_r, plen_nxt;

  logic [15:0] cap_ext, cap_used;
  logic [15:0] check_len, len;
  logic        residue_ok;

  assign cap_ext  = {3'b000, buffer_capacity};
  assign cap_used = (cap_ext < MaxBuf) ? cap_ext : MaxBuf;
  assign pop      = item_valid && (!out_valid_r || out_ready);
  assign len      = count_r - check_len;

  always_comb begin
    unique case (fcs_mode)
      MODE_NONE: begin
        check_len  = 16'd0;
        residue_ok = 1'b1;
      end
      MODE_SUM: begin
        check_len  = 16'd1;
        residue_ok = (acc_r[7:0] == 8'h00);
      end
      MODE_FCS16: begin
        check_len  = 16'd2;
        residue_ok = (acc_r[15:0] == FCS16_GOOD);
      end
      MODE_FCS32: begin
        check_len  = 16'd4;
        residue_ok = (acc_r == FCS32_GOOD);
      end
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    status_nxt = ST_OOS;
    store_nxt  = 1'b0;
    data_nxt   = 8'h00;
    index_nxt  = 16'h0000;
    plen_nxt   = 16'h0000;
    unique case (item.kind)
      KIND_START: begin
        status_nxt = ST_START;
        count_nxt  = 16'h0000;
        unique case (fcs_mode)
          MODE_NONE:  acc_nxt = acc_r;
          MODE_SUM:   acc_nxt = 32'h0000_0000;
          MODE_FCS16: acc_nxt = 32'h0000_FFFF;
          MODE_FCS32: acc_nxt = 32'hFFFF_FFFF;
        endcase
      end
      KIND_DATA: begin
        status_nxt = ST_DATA;
        data_nxt   = item.data;
        index_nxt  = count_r;
        store_nxt  = (count_r < cap_used);
        if (count_r != 16'hFFFF) begin
          count_nxt = count_r + 16'd1;
        end
        unique case (fcs_mode)
          MODE_NONE:  acc_nxt = acc_r;
          MODE_SUM:   acc_nxt = acc_r + {24'h000000, item.data};
          MODE_FCS16: acc_nxt = {16'h0000, fcs16_byte(acc_r[15:0], item.data)};
          MODE_FCS32: acc_nxt = fcs32_byte(acc_r, item.data);
        endcase
      end
      KIND_ESC: begin
        status_nxt = ST_ESCAPE;
      end
      KIND_CLOSE: begin
        // Too short first, then too large, then the residue.
        if (count_r < check_len) begin
          status_nxt = ST_BAD;
        end else if (len >= cap_used) begin
          status_nxt = ST_LARGE;
        end else if (!residue_ok) begin
          status_nxt = ST_BAD;
        end else begin
          status_nxt = ST_GOOD;
          plen_nxt   = len;
        end
      end
      KIND_OOS: begin
        status_nxt = ST_OOS;
      end
      default: begin
        status_nxt = ST_OOS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= 16'h0000;
      acc_r       <= 32'h0000_0000;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        count_r     <= count_nxt;
        acc_r       <= acc_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= status_nxt;
      store_r  <= store_nxt;
      data_r   <= data_nxt;
      index_r  <= index_nxt;
      plen_r   <= plen_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign status         = status_r;
  assign store_byte     = store_r;
  assign data_byte      = data_r;
  assign byte_index     = index_r;
  assign payload_length = plen_r;

endmodule

`default_nettype wire

// File: rtl/hdlc_frame_receiver_fcs_check.sv
// HDLC async frame receiver with FCS check: configuration registers and the
// front end, queue and back end. Depends on hfrx_pkg, hfrx_front, hfrx_fifo, hfrx_back.
//
// Usage:
//   The in_ stream carries one raw line byte per word in in_tdata. Every
//   accepted byte produces exactly one word on the out_ stream: out_tuser
//   carries the status code, out_tdata the store flag, decoded byte, byte
//   index and payload length (zero unless they apply to that status).
//   A byte accepted on in_ is registered in the queue and then in the
//   output register, from which it is presented on out_. While out_tready
//   stays high the block takes one byte per cycle sustained; the byte-wide
//   FCS16/FCS32 update in the back end is combinational.
//   A two-word queue separates framing from checking, so in_tready stays high
//   while out_tready is low until the queue and the output register fill,
//   after which the input stalls; nothing is dropped.
//   Reset (rst_n low, synchronous) leaves the receiver idle, hunting for a
//   flag, with FCS32 selected and a buffer capacity of 4096 bytes.
//   cfg_wr_en writes cfg_wdata to register cfg_index (0 fcs_mode,
//   1 buffer_capacity); write only while the receiver is idle.
`timescale 1ns / 1ps
`default_nettype none

module hdlc_frame_receiver_fcs_check #(
  parameter int MAX_BUFFER = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [0] store_byte, [8:1] data_byte,
                                       // [24:9] byte_index, [40:25] payload_length
  output logic [2:0]       out_tuser,  // [2:0] status
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_wdata
);
  import hfrx_pkg::*;

  logic [1:0]  fcs_mode_r;
  logic [12:0] capacity_r;

  item_t       front_item, back_item;
  logic        push, fifo_full, pop, fifo_valid;
  logic        store_byte;
  logic [7:0]  data_byte;
  logic [15:0] byte_index, payload_length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_mode_r <= MODE_FCS32;
      capacity_r <= 13'd4096;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_FCS_MODE) begin
        fcs_mode_r <= cfg_wdata[1:0];
      end else begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  assign in_tready = !fifo_full;
  assign push      = in_tvalid && !fifo_full;

  hfrx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rx_byte (in_tdata),
    .item    (front_item)
  );

  hfrx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (fifo_full),
    .pop       (pop),
    .pop_valid (fifo_valid),
    .pop_item  (back_item)
  );

  hfrx_back #(
    .MAX_BUFFER (MAX_BUFFER)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fcs_mode        (fcs_mode_r),
    .buffer_capacity (capacity_r),
    .item_valid      (fifo_valid),
    .item            (back_item),
    .pop             (pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .status          (out_tuser),
    .store_byte      (store_byte),
    .data_byte       (data_byte),
    .byte_index      (byte_index),
    .payload_length  (payload_length)
  );

  assign out_tdata = {7'b0000000, payload_length, byte_index, data_byte, store_byte};

endmodule

`default_nettype wire
